// File: sv/tlpt_pkg.sv
// Shared constants and codes for the two-level page table block.
package tlpt_pkg;

    localparam int DIR_ENTRIES       = 1024;
    localparam int ENTRIES_PER_TABLE = 1024;
    localparam int IDX_W             = 10;
    localparam int FRAME_W           = 20;
    localparam int FLAGS_W           = 12;
    localparam int TABLE_SLOTS_DEF   = 16;

    localparam logic [FRAME_W-1:0] BASE_FRAME_RESET = 20'd256;
    localparam logic [FLAGS_W-1:0] PRESENT_BIT      = 12'h001;

    localparam logic FUNC_MAP       = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

endpackage

// File: sv/two_level_page_table_map_translate.sv
// Two-level page table: the directory and the table store sit in synchronous memories.
// After reset the block runs a clearing pass over the TABLE_SLOTS * 1024 table words,
// zeroing the directory and the table store; in_ready stays low until it ends, while
// writes of the base frame (cfg_we) are taken at any time. A table word of zero means the
// entry was never written. Each request is then handled one at a time: the directory read
// is registered when the request is accepted, and a map finishes in S_DIR with its writes
// and result. A translate that finds a table needs a second dependent read of the table
// memory and finishes in S_TAB. The result goes into an output register; if it has not
// been taken when the next result is due, the block waits for out_ready.
module two_level_page_table_map_translate #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] virt_addr,
    input  logic [31:0] phys_addr,
    input  logic [11:0] page_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frame_addr,
    output logic        not_mapped,
    output logic        table_created,
    output logic        pool_exhausted
);

    localparam int STORE_DEPTH = TABLE_SLOTS * tlpt_pkg::ENTRIES_PER_TABLE;
    localparam int SAW         = $clog2(STORE_DEPTH);
    localparam int NSW         = $clog2(TABLE_SLOTS + 1);
    localparam int IW          = tlpt_pkg::IDX_W;
    localparam int FW          = tlpt_pkg::FRAME_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_DIR, S_TAB} state_t;

    state_t          state_reg;
    logic [SAW-1:0]  clr_cnt_reg;
    logic [NSW-1:0]  next_slot_reg;
    logic [FW-1:0]   base_frame_reg;

    logic            func_reg;
    logic [IW-1:0]   di_reg;
    logic [IW-1:0]   ti_reg;
    logic [FW-1:0]   ppn_reg;
    logic [11:0]     flags_reg;

    logic            out_valid_reg;
    logic [31:0]     frame_addr_reg;
    logic            not_mapped_reg;
    logic            table_created_reg;
    logic            pool_exhausted_reg;

    logic [31:0]     dir_mem [tlpt_pkg::DIR_ENTRIES];
    logic [31:0]     tab_mem [STORE_DEPTH];
    logic [31:0]     dir_rdata_reg;
    logic [31:0]     tab_rdata_reg;

    logic            accept;
    logic            out_free;
    logic            clearing;
    logic            is_map;
    logic            dir_empty;
    logic [FW-1:0]   slot_diff;
    logic            slot_ok;
    logic            pool_full;
    logic            map_alloc;
    logic            map_exhausted;
    logic            xlate_walk;
    logic [FW-1:0]   sel_slot;
    logic [FW-1:0]   alloc_frame;
    logic [19:0]     tab_addr_full;
    logic [SAW-1:0]  tab_addr;
    logic            dir_we;
    logic [IW-1:0]   dir_waddr;
    logic [31:0]     dir_wdata;
    logic            tab_we;
    logic [SAW-1:0]  tab_waddr;
    logic [31:0]     tab_wdata;
    logic            tab_re;
    logic            dir_finish;

    assign clearing = (state_reg == S_CLEAR);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Decode of the directory word that came back for the current request.
    assign is_map    = (func_reg == tlpt_pkg::FUNC_MAP);
    assign dir_empty = (dir_rdata_reg == 32'd0);
    assign slot_diff = dir_rdata_reg[31:12] - base_frame_reg;
    assign slot_ok   = (slot_diff < FW'(next_slot_reg));
    assign pool_full = (next_slot_reg == NSW'(TABLE_SLOTS));

    assign map_alloc     = is_map && dir_empty && !pool_full;
    assign map_exhausted = is_map && (dir_empty ? pool_full : !slot_ok);
    assign xlate_walk    = !is_map && !dir_empty && slot_ok;

    assign sel_slot      = (is_map && dir_empty) ? FW'(next_slot_reg) : slot_diff;
    assign alloc_frame   = base_frame_reg + FW'(next_slot_reg);
    assign tab_addr_full = {sel_slot[IW-1:0], ti_reg};
    assign tab_addr      = tab_addr_full[SAW-1:0];

    // A translate that walks to the table leaves S_DIR at once; everything else
    // finishes in S_DIR and needs a free output register.
    assign dir_finish = (state_reg == S_DIR) && !xlate_walk && out_free;

    assign dir_we    = clearing || (dir_finish && map_alloc);
    assign dir_waddr = clearing ? clr_cnt_reg[IW-1:0] : di_reg;
    assign dir_wdata = clearing ? 32'd0 : {alloc_frame, flags_reg};

    assign tab_we    = clearing || (dir_finish && is_map && !map_exhausted);
    assign tab_waddr = clearing ? clr_cnt_reg : tab_addr;
    assign tab_wdata = clearing ? 32'd0
                                : {ppn_reg, flags_reg | tlpt_pkg::PRESENT_BIT};
    assign tab_re    = (state_reg == S_DIR) && xlate_walk;

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (accept)
        begin
            dir_rdata_reg <= dir_mem[virt_addr[31:22]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        if (tab_re)
        begin
            tab_rdata_reg <= tab_mem[tab_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            clr_cnt_reg        <= '0;
            next_slot_reg      <= '0;
            base_frame_reg     <= tlpt_pkg::BASE_FRAME_RESET;
            out_valid_reg      <= 1'b0;
            func_reg           <= tlpt_pkg::FUNC_MAP;
            di_reg             <= '0;
            ti_reg             <= '0;
            ppn_reg            <= '0;
            flags_reg          <= '0;
            frame_addr_reg     <= '0;
            not_mapped_reg     <= 1'b0;
            table_created_reg  <= 1'b0;
            pool_exhausted_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_frame_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + SAW'(1);
                    if (clr_cnt_reg == SAW'(STORE_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func;
                        di_reg    <= virt_addr[31:22];
                        ti_reg    <= virt_addr[21:12];
                        ppn_reg   <= phys_addr[31:12];
                        flags_reg <= page_flags;
                        state_reg <= S_DIR;
                    end
                end
                S_DIR:
                begin
                    if (xlate_walk)
                    begin
                        state_reg <= S_TAB;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        frame_addr_reg     <= 32'd0;
                        not_mapped_reg     <= !is_map;
                        table_created_reg  <= map_alloc;
                        pool_exhausted_reg <= map_exhausted;
                        if (map_alloc)
                        begin
                            next_slot_reg <= next_slot_reg + NSW'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_TAB:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        frame_addr_reg     <= {tab_rdata_reg[31:12], 12'd0};
                        not_mapped_reg     <= (tab_rdata_reg == 32'd0);
                        table_created_reg  <= 1'b0;
                        pool_exhausted_reg <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_addr     = frame_addr_reg;
    assign not_mapped     = not_mapped_reg;
    assign table_created  = table_created_reg;
    assign pool_exhausted = pool_exhausted_reg;

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg <= NSW'(TABLE_SLOTS))
        else $error("pool slot counter ran past the pool");

    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        (next_slot_reg != $past(next_slot_reg)) |->
            (out_valid_reg && table_created_reg))
        else $error("pool slot taken without a table_created beat");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(table_created_reg && pool_exhausted_reg)
                          && !(not_mapped_reg && (frame_addr_reg != 32'd0)))
        else $error("inconsistent result beat");

    a_no_write_on_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAB) |-> (!tab_we && !dir_we))
        else $error("memory write during a translate walk");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!in_ready && !out_valid_reg))
        else $error("request traffic during the clearing pass");

endmodule

// File: test/tb_two_level_page_table_map_translate.sv
// Self-checking testbench for the two-level page table map and translate block.
module tb_two_level_page_table_map_translate;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW            = tlpt_pkg::FRAME_W;
    localparam int SLOTS         = tlpt_pkg::TABLE_SLOTS_DEF;
    localparam int STORE_DEPTH   = SLOTS * tlpt_pkg::ENTRIES_PER_TABLE;
    localparam int QUIET_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 305;
    localparam int HOT_DIRS      = 24;

    typedef struct packed {
        logic [31:0] frame_addr;
        logic        not_mapped;
        logic        table_created;
        logic        pool_exhausted;
    } walk_result_t;

    // Tracks the expected table contents and the results still owed by the block.
    class page_walk_scoreboard;
        bit [31:0]          dir_words[tlpt_pkg::DIR_ENTRIES];
        bit [31:0]          table_words[STORE_DEPTH];
        bit                 entry_valid[STORE_DEPTH];
        int unsigned        slots_used;
        bit [FW-1:0]        base_frame;
        walk_result_t       owed_results[$];
        int unsigned        mismatches;

        function new();
            base_frame = tlpt_pkg::BASE_FRAME_RESET;
            slots_used = 0;
            mismatches = 0;
        endfunction

        // A directory word names a table only if it lands on a slot already handed out.
        function int unsigned slot_from_dir(bit [31:0] dword);
            bit [FW-1:0] rel;
            rel = dword[31:12] - base_frame;
            if (rel >= slots_used || rel >= SLOTS)
                return SLOTS;
            return rel;
        endfunction

        function void note_request(logic op, logic [31:0] va, logic [31:0] pa,
                                   logic [tlpt_pkg::FLAGS_W-1:0] flags);
            int unsigned  di;
            int unsigned  ti;
            int unsigned  slot;
            int unsigned  idx;
            int           i;
            bit [31:0]    dword;
            walk_result_t r;
            di    = va[31:22];
            ti    = va[21:12];
            dword = dir_words[di];
            r     = '0;
            if (op == tlpt_pkg::FUNC_TRANSLATE)
            begin
                slot = (dword == 0) ? SLOTS : slot_from_dir(dword);
                if (slot >= SLOTS)
                    r.not_mapped = 1'b1;
                else
                begin
                    idx = slot * tlpt_pkg::ENTRIES_PER_TABLE + ti;
                    if (!entry_valid[idx] || table_words[idx] == 0)
                        r.not_mapped = 1'b1;
                    else
                        r.frame_addr = {table_words[idx][31:12], 12'h000};
                end
            end
            else
            begin
                if (dword == 0)
                begin
                    if (slots_used >= SLOTS)
                    begin
                        r.pool_exhausted = 1'b1;
                        slot = SLOTS;
                    end
                    else
                    begin
                        slot = slots_used;
                        slots_used++;
                        for (i = 0; i < tlpt_pkg::ENTRIES_PER_TABLE; i++)
                            entry_valid[slot * tlpt_pkg::ENTRIES_PER_TABLE + i] = 1'b0;
                        // The frame number wraps at 20 bits; a zero word stays empty.
                        dir_words[di] = {base_frame + FW'(slot), flags};
                        r.table_created = 1'b1;
                    end
                end
                else
                begin
                    slot = slot_from_dir(dword);
                    if (slot >= SLOTS)
                        r.pool_exhausted = 1'b1;
                end
                if (!r.pool_exhausted)
                begin
                    idx = slot * tlpt_pkg::ENTRIES_PER_TABLE + ti;
                    table_words[idx] = {pa[31:12], flags | tlpt_pkg::PRESENT_BIT};
                    entry_valid[idx] = 1'b1;
                end
            end
            owed_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH %s", $realtime, what);
        endtask

        task check_result(walk_result_t got);
            walk_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing owed, frame_addr=%h",
                                          got.frame_addr));
                return;
            end
            want = owed_results.pop_front();
            if (got.frame_addr !== want.frame_addr)
                report_mismatch($sformatf("frame_addr got %h want %h",
                                          got.frame_addr, want.frame_addr));
            if (got.not_mapped !== want.not_mapped)
                report_mismatch($sformatf("not_mapped got %b want %b",
                                          got.not_mapped, want.not_mapped));
            if (got.table_created !== want.table_created)
                report_mismatch($sformatf("table_created got %b want %b",
                                          got.table_created, want.table_created));
            if (got.pool_exhausted !== want.pool_exhausted)
                report_mismatch($sformatf("pool_exhausted got %b want %b",
                                          got.pool_exhausted, want.pool_exhausted));
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [FW-1:0]                cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic                         func;
    logic [31:0]                  virt_addr;
    logic [31:0]                  phys_addr;
    logic [tlpt_pkg::FLAGS_W-1:0] page_flags;
    logic                         out_valid;
    logic                         out_ready;
    logic [31:0]                  frame_addr;
    logic                         not_mapped;
    logic                         table_created;
    logic                         pool_exhausted;

    page_walk_scoreboard sb;
    int                  in_idle_pct;
    int                  out_idle_pct;
    int                  phase_no;
    int                  hold_left;
    bit                  hold_done;
    int                  quiet_cycles;
    logic [9:0]          hot_dirs[HOT_DIRS];

    two_level_page_table_map_translate DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .virt_addr      (virt_addr),
        .phys_addr      (phys_addr),
        .page_flags     (page_flags),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_addr     (frame_addr),
        .not_mapped     (not_mapped),
        .table_created  (table_created),
        .pool_exhausted (pool_exhausted)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Receiver side: random back-pressure, plus one long hold-off while the sender keeps going.
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
    end

    always @(posedge clk)
    begin
        if (phase_no == 4 && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin : beat_monitor
        walk_result_t got;
        if (rst_n === 1'b1)
        begin
            if (in_valid && in_ready)
                sb.note_request(func, virt_addr, phys_addr, page_flags);
            if (out_valid === 1'b1 && out_ready)
            begin
                got = {frame_addr, not_mapped, table_created, pool_exhausted};
                sb.check_result(got);
            end
        end
    end

    // The clearing pass after reset keeps the input closed.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_request(logic op, logic [31:0] va, logic [31:0] pa,
                                logic [tlpt_pkg::FLAGS_W-1:0] flags);
        if ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid   <= 1'b1;
        func       <= op;
        virt_addr  <= va;
        phys_addr  <= pa;
        page_flags <= flags;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
    endtask

    // Changes the pool base only once the block has drained.
    task automatic write_base(logic [FW-1:0] value);
        in_valid <= 1'b0;
        // This wait lets the monitor note a beat accepted at the same edge.
        @(posedge clk);
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.base_frame = value;
    endtask

    function automatic logic [31:0] page_va(logic [9:0] di, logic [9:0] ti);
        return {di, ti, 12'($urandom)};
    endfunction

    task automatic random_phase(int count);
        int          n;
        logic [9:0]  di;
        logic [9:0]  ti;
        logic [11:0] flags;
        logic        op;
        int          pick;
        for (n = 0; n < count; n++)
        begin
            di = ($urandom_range(99) < 85) ? hot_dirs[$urandom_range(HOT_DIRS - 1)]
                                           : 10'($urandom);
            pick = $urandom_range(99);
            if (pick < 60)
                ti = 10'($urandom_range(7));
            else if (pick < 80)
                ti = $urandom_range(1) ? 10'h3FF : 10'h000;
            else
                ti = 10'($urandom);
            pick = $urandom_range(99);
            if (pick < 10)
                flags = 12'h000;
            else if (pick < 20)
                flags = 12'hFFF;
            else
                flags = 12'($urandom);
            op = ($urandom_range(99) < 45) ? tlpt_pkg::FUNC_MAP : tlpt_pkg::FUNC_TRANSLATE;
            send_request(op, page_va(di, ti), $urandom, flags);
        end
    endtask

    initial
    begin : stimulus
        int p;
        int h;
        logic [FW-1:0] phase_base[PHASES];
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        func         = tlpt_pkg::FUNC_MAP;
        virt_addr    = '0;
        phys_addr    = '0;
        page_flags   = '0;
        in_idle_pct  = 29;
        out_idle_pct = 69;
        phase_no     = -1;
        quiet_cycles = 0;
        hot_dirs[0]  = 10'h000;
        hot_dirs[1]  = 10'h3FF;
        hot_dirs[2]  = 10'h005;
        for (h = 3; h < HOT_DIRS; h++)
            hot_dirs[h] = 10'($urandom);
        phase_base[0] = tlpt_pkg::BASE_FRAME_RESET;
        phase_base[1] = 20'd1;
        phase_base[2] = tlpt_pkg::BASE_FRAME_RESET;
        phase_base[3] = 20'hFFFFF;
        phase_base[4] = tlpt_pkg::BASE_FRAME_RESET;
        phase_base[5] = 20'($urandom_range(20'hFFFFF, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // With a zero base and zero flags the first table leaves a zero directory word,
        // so the region still reads as empty and the next map allocates again.
        write_base(20'h00000);
        send_request(tlpt_pkg::FUNC_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0000_0000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_MAP,       32'h0000_1000, 32'h0000_0000, 12'hFFF);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0000_1ABC, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0000_2000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'hFFC0_0000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_MAP,       32'hFFFF_F000, 32'hFFFF_F000, 12'h001);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'hFFFF_FFFF, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_MAP,       32'hFFFF_F123, 32'h1234_5678, 12'h800);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'hFFFF_F000, 32'h0,         12'h000);

        // Moving the base re-aims old directory words at other slots or at none.
        write_base(20'hFFFFF);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h003F_F000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'hFFFF_F000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_MAP,       32'hFFFF_E000, 32'hA5A5_A5A5, 12'h5A5);
        send_request(tlpt_pkg::FUNC_MAP,       32'h0140_3000, 32'h5A5A_5A5A, 12'hA5A);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0140_3FFF, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0140_4000, 32'h0,         12'h000);
        write_base(20'd1);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0000_1000, 32'h0,         12'h000);
        send_request(tlpt_pkg::FUNC_MAP,       32'h0000_1000, 32'h0000_0000, 12'h000);
        send_request(tlpt_pkg::FUNC_TRANSLATE, 32'h0000_1000, 32'h0,         12'h000);

        for (p = 0; p < PHASES; p++)
        begin
            write_base(phase_base[p]);
            in_idle_pct  = (p < 2) ? 29 : (p < 4) ? 69 : 0;
            out_idle_pct = (p < 2) ? 69 : (p < 4) ? 29 : 0;
            phase_no     = p;
            random_phase(PHASE_ITEMS);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
